FILE: design/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg: shared constants and tables for the tyre force curve block
// Fixed-point angle constants, CORDIC arctangent table, register map.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 20;

  localparam int REG_W   = 24;
  localparam int IDX_W   = 3;
  localparam int SLIP_W  = 24;
  localparam int MU_W    = 18;
  localparam int FORCE_W = 32;

  // CORDIC word widths
  localparam int ZW  = 34;  // accumulated angle, Q2.30
  localparam int CW  = 60;  // vectoring x/y
  localparam int SW  = 34;  // rotation x/y
  localparam int MW  = 35;  // rotation residual angle
  localparam int MN_W = 34; // mu * normal force, Q.16
  localparam int MN_HALF = 17;

  localparam logic signed [MW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [MW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [MW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [SW-1:0] INV_GAIN_Q30 = 34'sd652032874;

  // 2*pi reduction: quotient from a reciprocal multiply, floor(2^48 / (2*pi * 2^30))
  localparam logic [32:0] TWO_PI_U     = 33'd6746518852;
  localparam logic [15:0] TWO_PI_RECIP = 16'd41721;
  localparam int          RECIP_SH     = 48;

  typedef enum logic [IDX_W-1:0] {
    REG_STIFFNESS_B  = 3'd0,
    REG_SHAPE_C      = 3'd1,
    REG_PEAK_D       = 3'd2,
    REG_CURVATURE_E  = 3'd3,
    REG_VERT_SHIFT   = 3'd4,
    REG_HORIZ_SHIFT  = 3'd5,
    REG_NORMAL_FORCE = 3'd6
  } reg_idx_t;

  localparam logic [REG_W-1:0] RST_STIFFNESS_B  = 24'd32768;
  localparam logic [REG_W-1:0] RST_SHAPE_C      = 24'd108134;
  localparam logic [REG_W-1:0] RST_PEAK_D       = 24'd65536;
  localparam logic [REG_W-1:0] RST_CURVATURE_E  = 24'd52429;
  localparam logic [REG_W-1:0] RST_VERT_SHIFT   = 24'd0;
  localparam logic [REG_W-1:0] RST_HORIZ_SHIFT  = 24'd0;
  localparam logic [REG_W-1:0] RST_NORMAL_FORCE = 24'd256000;

  // atan(2^-k) in Q2.30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int k);
    logic signed [ZW-1:0] r;
    case (k)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/tmf_atan.sv
// ----------------------------------------------------------------------------
// tmf_atan: pipelined vectoring CORDIC arctangent
// Input Q.FRAC, clamped to +-2^24, result Q2.30. One stage per iteration.
// ----------------------------------------------------------------------------
module tmf_atan #(
  parameter int IN_W  = 33,
  parameter int FRAC  = tmf_pkg::FRAC_BITS_DEF,
  parameter int STEPS = tmf_pkg::CORDIC_STEPS_DEF,
  parameter int SB_W  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic signed [IN_W-1:0]         in_val,
  input  logic [SB_W-1:0]                in_sb,
  output logic                           out_v,
  output logic signed [tmf_pkg::ZW-1:0]  out_z,
  output logic [SB_W-1:0]                out_sb
);
  import tmf_pkg::*;

  logic                 v_r  [0:STEPS];
  logic signed [CW-1:0] x_r  [0:STEPS];
  logic signed [CW-1:0] y_r  [0:STEPS];
  logic signed [ZW-1:0] z_r  [0:STEPS];
  logic [SB_W-1:0]      sb_r [0:STEPS];

  logic signed [63:0] v64;
  logic signed [63:0] vc;
  logic signed [63:0] lim;
  logic signed [63:0] ys;

  always_comb begin
    v64 = 64'(in_val);
    lim = 64'sd1 <<< (FRAC + 24);
    vc  = v64;
    if (v64 > lim)  vc = lim;
    if (v64 < -lim) vc = -lim;
    ys  = vc <<< (30 - FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= CW'(64'sd1 <<< 30);
      y_r[0]  <= ys[CW-1:0];
      z_r[0]  <= '0;
      sb_r[0] <= in_sb;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam int K = i % 32;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] yss;
    assign xs  = x_r[i] >>> K;
    assign yss = y_r[i] >>> K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i+1] <= sb_r[i];
        if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - yss;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - atan_q30(K);
        end else begin
          x_r[i+1] <= x_r[i] + yss;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + atan_q30(K);
        end
      end
    end
  end

  assign out_v  = v_r[STEPS];
  assign out_z  = z_r[STEPS];
  assign out_sb = sb_r[STEPS];

endmodule

FILE: design/tmf_sin.sv
// ----------------------------------------------------------------------------
// tmf_sin: pipelined sine with range reduction and rotation CORDIC
// Angle Q2.30 of any size: quotient by 2*pi from a reciprocal multiply, one
// correcting subtract, wrap to [-pi, pi], fold to [-pi/2, pi/2], then one
// stage per iteration.
// ----------------------------------------------------------------------------
module tmf_sin #(
  parameter int ANG_W = 42,
  parameter int STEPS = tmf_pkg::CORDIC_STEPS_DEF,
  parameter int SB_W  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic signed [ANG_W-1:0]        in_ang,
  input  logic [SB_W-1:0]                in_sb,
  output logic                           out_v,
  output logic signed [tmf_pkg::SW-1:0]  out_sin,
  output logic [SB_W-1:0]                out_sb
);
  import tmf_pkg::*;

  localparam int QB   = ANG_W - 32;   // quotient bits
  localparam int RP_W = ANG_W + 16;   // reciprocal product
  localparam int RW   = MW - 1;       // remainder before correction, < 4*pi

  // range reduction: magnitude, quotient estimate, remainder
  logic             rv_r   [0:2];
  logic             neg_r  [0:2];
  logic [ANG_W-1:0] mag_r  [0:1];
  logic [SB_W-1:0]  rsb_r  [0:2];
  logic [QB-1:0]    q1_r;
  logic [RW-1:0]    rem2_r;
  logic [RP_W-1:0]  qprod;
  logic [ANG_W-1:0] qsub;
  logic [ANG_W-1:0] rem_full;

  // estimate is the true quotient or one below it
  assign qprod    = RP_W'(mag_r[0]) * RP_W'(TWO_PI_RECIP);
  assign qsub     = ANG_W'(q1_r) * ANG_W'(TWO_PI_U);
  assign rem_full = mag_r[1] - qsub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
      rv_r[1] <= 1'b0;
      rv_r[2] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= in_v;
      rv_r[1] <= rv_r[0];
      rv_r[2] <= rv_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= in_ang[ANG_W-1];
      mag_r[0] <= in_ang[ANG_W-1] ? ANG_W'(-in_ang) : ANG_W'(in_ang);
      rsb_r[0] <= in_sb;
      neg_r[1] <= neg_r[0];
      mag_r[1] <= mag_r[0];
      rsb_r[1] <= rsb_r[0];
      q1_r     <= qprod[RP_W-1:RECIP_SH];
      neg_r[2] <= neg_r[1];
      rsb_r[2] <= rsb_r[1];
      rem2_r   <= rem_full[RW-1:0];
    end
  end

  // signed remainder, then wrap into [-pi, pi]
  logic [RW-1:0]        rem_u;
  logic signed [MW-1:0] rem;
  logic signed [MW-1:0] wrap_nxt;
  logic                 wv_r;
  logic signed [MW-1:0] wrap_r;
  logic [SB_W-1:0]      wsb_r;

  always_comb begin
    rem_u = rem2_r;
    if (rem2_r >= RW'(TWO_PI_U)) rem_u = rem2_r - RW'(TWO_PI_U);
    rem = MW'(signed'({1'b0, rem_u}));
    if (neg_r[2]) rem = -rem;
    wrap_nxt = rem;
    if (rem > PI_Q30)  wrap_nxt = rem - TWO_PI_Q30;
    if (rem < -PI_Q30) wrap_nxt = rem + TWO_PI_Q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= 1'b0;
    end else if (en) begin
      wv_r <= rv_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrap_r <= wrap_nxt;
      wsb_r  <= rsb_r[2];
    end
  end

  // fold by sin(pi - a) = sin(a), then rotation
  logic signed [MW-1:0] fold_nxt;
  logic                 v_r  [0:STEPS];
  logic signed [SW-1:0] x_r  [0:STEPS];
  logic signed [SW-1:0] y_r  [0:STEPS];
  logic signed [MW-1:0] m_r  [0:STEPS];
  logic [SB_W-1:0]      sb_r [0:STEPS];

  always_comb begin
    fold_nxt = wrap_r;
    if (wrap_r > HALF_PI_Q30)  fold_nxt = PI_Q30 - wrap_r;
    if (wrap_r < -HALF_PI_Q30) fold_nxt = -PI_Q30 - wrap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= wv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= INV_GAIN_Q30;
      y_r[0]  <= '0;
      m_r[0]  <= fold_nxt;
      sb_r[0] <= wsb_r;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam int K = i % 32;
    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] ys;
    logic signed [MW-1:0] tab;
    assign xs  = x_r[i] >>> K;
    assign ys  = y_r[i] >>> K;
    assign tab = MW'(atan_q30(K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i+1] <= sb_r[i];
        if (m_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          m_r[i+1] <= m_r[i] - tab;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          m_r[i+1] <= m_r[i] + tab;
        end
      end
    end
  end

  assign out_v   = v_r[STEPS];
  assign out_sin = y_r[STEPS];
  assign out_sb  = sb_r[STEPS];

endmodule

FILE: design/tire_magic_formula_force.sv
// ----------------------------------------------------------------------------
// tire_magic_formula_force: magic formula tyre force, fixed point, pipelined
// f = D*sin(C*atan(B*(1-E)*x + E*atan(B*x))) + Sv, x = slip + Sh,
// force = mu * Fz * f, saturated to signed Q24.8.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transaction when
//  --------+-------------------------------------------+-------------------
//  input   | in_valid/in_ready, in_slip, in_friction_coeff | valid & ready
//  output  | out_valid/out_ready, out_force_res, out_saturated | valid & ready
//  config  | cfg_we, cfg_idx, cfg_data                 | cfg_we high
//
// One transaction per clock sustained while the output does not stall.
// Latency is set by the three unrolled CORDIC chains
// (two arctangents, one sine) and the 2*pi reduction stages.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall at the output fills a one-entry skid register; while it is full
// the whole pipeline holds and in_ready is low. in_ready is registered.
// ----------------------------------------------------------------------------
module tire_magic_formula_force #(
  parameter int FRAC_BITS    = tmf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = tmf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [tmf_pkg::IDX_W-1:0]          cfg_idx,
  input  logic [tmf_pkg::REG_W-1:0]          cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tmf_pkg::SLIP_W-1:0]  in_slip,
  input  logic [tmf_pkg::MU_W-1:0]           in_friction_coeff,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tmf_pkg::FORCE_W-1:0] out_force_res,
  output logic                               out_saturated
);
  import tmf_pkg::*;

  // datapath widths
  localparam int X_W     = SLIP_W + 1;
  localparam int BXP_W   = REG_W + X_W;
  localparam int BX_W    = BXP_W - FRAC_BITS;
  localparam int OME_W   = 26;
  localparam int BMEP_W  = REG_W + OME_W;
  localparam int BME_W   = BMEP_W - FRAC_BITS;
  localparam int BMEX_W  = BME_W + X_W;
  localparam int ARG1_W  = BMEX_W - FRAC_BITS;
  localparam int EZ_W    = REG_W + ZW;
  localparam int EZS_W   = EZ_W - 30;
  localparam int ARG_W   = ((ARG1_W > EZS_W) ? ARG1_W : EZS_W) + 1;
  localparam int CP_W    = REG_W + ZW;
  localparam int ANG_W   = CP_W - FRAC_BITS;
  localparam int DP_W    = REG_W + SW;
  localparam int F_W     = DP_W - 30 + 1;
  localparam int MNP_W   = MU_W + REG_W;
  localparam int PP_W    = MN_HALF + 1 + F_W;
  localparam int SUM_W   = 64;
  localparam int SB1_W   = BME_W + X_W + MN_W;

  // ---------------- configuration registers ----------------
  logic signed [REG_W-1:0] b_r, c_r, d_r, e_r, sv_r, sh_r;
  logic [REG_W-1:0]        nf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r  <= RST_STIFFNESS_B;
      c_r  <= RST_SHAPE_C;
      d_r  <= RST_PEAK_D;
      e_r  <= RST_CURVATURE_E;
      sv_r <= RST_VERT_SHIFT;
      sh_r <= RST_HORIZ_SHIFT;
      nf_r <= RST_NORMAL_FORCE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STIFFNESS_B:  b_r  <= cfg_data;
        REG_SHAPE_C:      c_r  <= cfg_data;
        REG_PEAK_D:       d_r  <= cfg_data;
        REG_CURVATURE_E:  e_r  <= cfg_data;
        REG_VERT_SHIFT:   sv_r <= cfg_data;
        REG_HORIZ_SHIFT:  sh_r <= cfg_data;
        REG_NORMAL_FORCE: nf_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // global advance: pipeline moves unless the skid register is occupied
  logic en;
  logic skid_valid_r;
  assign en       = !skid_valid_r;
  assign in_ready = en;

  // ---------------- S1: slip shift, product seeds ----------------
  logic                     v1_r;
  logic signed [X_W-1:0]    x1_r;
  logic [MNP_W-1:0]         mnp1_r;
  logic signed [BMEP_W-1:0] bmep1_r;
  logic signed [OME_W-1:0]  ome;

  assign ome = (OME_W'(1) <<< FRAC_BITS) - OME_W'(e_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= X_W'(in_slip) + X_W'(sh_r);
      mnp1_r  <= MNP_W'(in_friction_coeff) * MNP_W'(nf_r);
      bmep1_r <= b_r * ome;
    end
  end

  // ---------------- S2: B*x, B*(1-E) ----------------
  logic                    v2_r;
  logic signed [BX_W-1:0]  bx2_r;
  logic signed [BME_W-1:0] bme2_r;
  logic signed [X_W-1:0]   x2_r;
  logic [MN_W-1:0]         mn2_r;
  logic signed [BXP_W-1:0] bxp;
  logic signed [BXP_W-1:0] bxs;
  logic signed [BMEP_W-1:0] bmes;

  assign bxp  = b_r * x1_r;
  assign bxs  = bxp >>> FRAC_BITS;
  assign bmes = bmep1_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx2_r  <= bxs[BX_W-1:0];
      bme2_r <= bmes[BME_W-1:0];
      x2_r   <= x1_r;
      mn2_r  <= mnp1_r[MNP_W-1:8];
    end
  end

  // ---------------- first arctangent: atan(B*x) ----------------
  logic                 va;
  logic signed [ZW-1:0] za;
  logic [SB1_W-1:0]     sba;

  tmf_atan #(
    .IN_W (BX_W),
    .FRAC (FRAC_BITS),
    .STEPS(CORDIC_STEPS),
    .SB_W (SB1_W)
  ) u_atan_bx (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v2_r),
    .in_val(bx2_r),
    .in_sb ({bme2_r, x2_r, mn2_r}),
    .out_v (va),
    .out_z (za),
    .out_sb(sba)
  );

  // ---------------- S3/S4: argument of the outer arctangent ----------------
  logic signed [BME_W-1:0]  bme_a;
  logic signed [X_W-1:0]    x_a;
  logic                     v3_r, v4_r;
  logic signed [BMEX_W-1:0] bmex3_r;
  logic signed [EZ_W-1:0]   ez3_r;
  logic [MN_W-1:0]          mn3_r, mn4_r;
  logic signed [ARG_W-1:0]  arg4_r;

  assign bme_a = sba[SB1_W-1 -: BME_W];
  assign x_a   = sba[MN_W +: X_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= va;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bmex3_r <= bme_a * x_a;
      ez3_r   <= e_r * za;
      mn3_r   <= sba[MN_W-1:0];
      arg4_r  <= ARG_W'(bmex3_r >>> FRAC_BITS) + ARG_W'(ez3_r >>> 30);
      mn4_r   <= mn3_r;
    end
  end

  // ---------------- second arctangent ----------------
  logic                 vb;
  logic signed [ZW-1:0] zb;
  logic [MN_W-1:0]      mnb;

  tmf_atan #(
    .IN_W (ARG_W),
    .FRAC (FRAC_BITS),
    .STEPS(CORDIC_STEPS),
    .SB_W (MN_W)
  ) u_atan_arg (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v4_r),
    .in_val(arg4_r),
    .in_sb (mn4_r),
    .out_v (vb),
    .out_z (zb),
    .out_sb(mnb)
  );

  // ---------------- S5/S6: sine angle C*atan ----------------
  logic                   v5_r, v6_r;
  logic signed [CP_W-1:0] cp5_r;
  logic signed [CP_W-1:0] cps;
  logic signed [ANG_W-1:0] ang6_r;
  logic [MN_W-1:0]        mn5_r, mn6_r;

  assign cps = cp5_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= vb;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp5_r  <= c_r * zb;
      mn5_r  <= mnb;
      ang6_r <= cps[ANG_W-1:0];
      mn6_r  <= mn5_r;
    end
  end

  // ---------------- sine ----------------
  logic                 vs;
  logic signed [SW-1:0] ys;
  logic [MN_W-1:0]      mns;

  tmf_sin #(
    .ANG_W(ANG_W),
    .STEPS(CORDIC_STEPS),
    .SB_W (MN_W)
  ) u_sin (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (v6_r),
    .in_ang (ang6_r),
    .in_sb  (mn6_r),
    .out_v  (vs),
    .out_sin(ys),
    .out_sb (mns)
  );

  // ---------------- S7/S8: f = D*sin + Sv ----------------
  logic                   v7_r, v8_r;
  logic signed [DP_W-1:0] dp7_r;
  logic signed [F_W-1:0]  f8_r;
  logic [MN_W-1:0]        mn7_r, mn8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v7_r <= vs;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp7_r <= d_r * ys;
      mn7_r <= mns;
      f8_r  <= F_W'(dp7_r >>> 30) + F_W'(sv_r);
      mn8_r <= mn7_r;
    end
  end

  // ---------------- S9: mu*Fz*f as two partial products ----------------
  logic                    v9_r;
  logic signed [PP_W-1:0]  plo9_r, phi9_r;
  logic signed [MN_HALF:0] mn_lo, mn_hi;

  assign mn_lo = signed'({1'b0, mn8_r[MN_HALF-1:0]});
  assign mn_hi = signed'({1'b0, mn8_r[MN_W-1:MN_HALF]});

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo9_r <= mn_lo * f8_r;
      phi9_r <= mn_hi * f8_r;
    end
  end

  // ---------------- S10: sum, scale, saturate ----------------
  logic                      v10_r;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   scaled;
  logic signed [FORCE_W-1:0] res_nxt;
  logic                      sat_nxt;
  logic signed [FORCE_W-1:0] res10_r;
  logic                      sat10_r;

  always_comb begin
    sum     = (SUM_W'(phi9_r) <<< MN_HALF) + SUM_W'(plo9_r);
    scaled  = sum >>> (FRAC_BITS + 8);
    res_nxt = scaled[FORCE_W-1:0];
    sat_nxt = 1'b0;
    if (scaled > 64'sd2147483647) begin
      res_nxt = 32'sh7fffffff;
      sat_nxt = 1'b1;
    end
    if (scaled < -64'sd2147483648) begin
      res_nxt = 32'sh80000000;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (en) v10_r <= v9_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res10_r <= res_nxt;
      sat10_r <= sat_nxt;
    end
  end

  // ---------------- output register and skid ----------------
  logic                      out_valid_r, out_valid_nxt;
  logic signed [FORCE_W-1:0] out_res_r, out_res_nxt;
  logic                      out_sat_r, out_sat_nxt;
  logic                      skid_valid_nxt;
  logic signed [FORCE_W-1:0] skid_res_r, skid_res_nxt;
  logic                      skid_sat_r, skid_sat_nxt;
  logic                      take;

  always_comb begin
    take           = out_valid_r & out_ready;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    out_sat_nxt    = out_sat_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    skid_sat_nxt   = skid_sat_r;
    if (skid_valid_r) begin
      // pipeline is frozen; drain skid once output is taken
      if (take) begin
        out_res_nxt    = skid_res_r;
        out_sat_nxt    = skid_sat_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (v10_r) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res10_r;
        out_sat_nxt   = sat10_r;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = res10_r;
        skid_sat_nxt   = sat10_r;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_sat_r  <= out_sat_nxt;
    skid_res_r <= skid_res_nxt;
    skid_sat_r <= skid_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_force_res = out_res_r;
  assign out_saturated = out_sat_r;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Tyre force curve testbench
// Drives slip / friction transactions through tire_magic_formula_force with
// random idling on both channels. A fixed-point predictor, reproducing the
// CORDIC arithmetic bit for bit, gives the expected force and saturation
// flag. Every result is checked in order against those expectations.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tmf_pkg::*;

  localparam int FB         = 16;
  localparam int STEPS      = 20;
  localparam int LATENCY    = 3 * STEPS + 18;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SLIP_W-1:0] in_slip = '0;
  logic [MU_W-1:0] in_friction_coeff = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FORCE_W-1:0] out_force_res;
  logic out_saturated;

  tire_magic_formula_force dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic signed [FORCE_W-1:0] force_val;
    logic sat;
  } force_t;

  // predictor's copy of the register file
  logic [REG_W-1:0] coeff [7];
  force_t force_q[$];
  int errors = 0;
  int idle_pct = 34;      // idle chance per cycle, both sides
  bit hold_off = 1'b0;    // receiver long hold-off request
  bit in_busy = 1'b0;     // in_valid still high after the last acceptance
  int quiet = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint shr(longint v, int s);
    return v >>> s;       // arithmetic, floor
  endfunction

  function automatic longint atan_table(int k);
    return longint'(atan_q30(k));
  endfunction

  function automatic longint cordic_atan(longint v);
    longint lim, x, y, z, nx;
    lim = longint'(1) << (FB + 24);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    x = longint'(1) << 30;
    y = v * (longint'(1) << (30 - FB));
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y < 0) begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        z -= atan_table(i);
      end else begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        z += atan_table(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint cordic_sin(longint a);
    longint m, x, y, nx, pi_v, tpi;
    pi_v = 64'sd3373259426;
    tpi  = 64'sd6746518852;
    m = a % tpi;          // truncating remainder, as in C
    if (m > pi_v) m -= tpi;
    if (m < -pi_v) m += tpi;
    if (m > 64'sd1686629713) m = pi_v - m;
    if (m < -64'sd1686629713) m = -pi_v - m;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (m >= 0) begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        m -= atan_table(i);
      end else begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        m += atan_table(i);
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic force_t tyre_force(logic signed [SLIP_W-1:0] slip,
                                        logic [MU_W-1:0] mu);
    longint b, c, d, e, sv, sh, nf, x, bx, bme, arg, ang, f, mn, r;
    force_t res;
    b  = longint'(signed'(coeff[REG_STIFFNESS_B]));
    c  = longint'(signed'(coeff[REG_SHAPE_C]));
    d  = longint'(signed'(coeff[REG_PEAK_D]));
    e  = longint'(signed'(coeff[REG_CURVATURE_E]));
    sv = longint'(signed'(coeff[REG_VERT_SHIFT]));
    sh = longint'(signed'(coeff[REG_HORIZ_SHIFT]));
    nf = longint'({40'd0, coeff[REG_NORMAL_FORCE]});
    x = longint'(slip) + sh;
    bx = shr(b * x, FB);
    bme = shr(b * ((longint'(1) << FB) - e), FB);
    arg = shr(bme * x, FB) + shr(e * cordic_atan(bx), 30);
    ang = shr(c * cordic_atan(arg), FB);
    f = shr(d * cordic_sin(ang), 30) + sv;
    mn = (longint'({46'd0, mu}) * nf) >>> 8;
    r = shr(mn * f, FB + 8);
    res.sat = 1'b0;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      res.sat = 1'b1;
    end
    if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.force_val = r[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  // drop in_valid once the last transaction has gone
  task automatic release_in();
    if (in_busy) begin
      in_valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(int idx, logic [REG_W-1:0] val);
    release_in();
    while (force_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx[IDX_W-1:0];
    cfg_data <= val;
    if (idx < 7) coeff[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // send one transaction; expectation pushed on acceptance
  task automatic send_slip(logic [SLIP_W-1:0] slip, logic [MU_W-1:0] mu);
    if ($urandom_range(99) < idle_pct) begin
      release_in();
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_slip <= slip;
    in_friction_coeff <= mu;
    do @(posedge clk); while (!in_ready);
    force_q.push_back(tyre_force(slip, mu));
    in_busy = 1'b1;
  endtask

  task automatic drain();
    release_in();
    while (force_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] rand_word();
    return REG_W'($urandom());
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_defaults();
    logic [SLIP_W-1:0] slips [8] = '{24'h000000, 24'h7FFFFF, 24'h800000,
      24'h010000, 24'hFF0000, 24'h001000, 24'hFFF000, 24'h000001};
    foreach (slips[i]) send_slip(slips[i], 18'h10000);
    send_slip(24'h020000, 18'h3FFFF);
    send_slip(24'hFE0000, 18'h00000);
    drain();
  endtask

  // extreme coefficients: huge atan argument, large sine angle, saturation
  task automatic test_extremes();
    write_reg(REG_STIFFNESS_B, 24'h7FFFFF);
    write_reg(REG_SHAPE_C, 24'h7FFFFF);
    write_reg(REG_PEAK_D, 24'h7FFFFF);
    write_reg(REG_NORMAL_FORCE, 24'hFFFFFF);
    send_slip(24'h7FFFFF, 18'h3FFFF);
    send_slip(24'h800000, 18'h3FFFF);
    send_slip(24'h000100, 18'h2AAAA);
    write_reg(REG_STIFFNESS_B, 24'h800000);
    write_reg(REG_SHAPE_C, 24'h800000);
    write_reg(REG_PEAK_D, 24'h800000);
    write_reg(REG_CURVATURE_E, 24'h800000);
    write_reg(REG_VERT_SHIFT, 24'h7FFFFF);
    write_reg(REG_HORIZ_SHIFT, 24'h800000);
    send_slip(24'h7FFFFF, 18'h3FFFF);
    send_slip(24'h123456, 18'h15555);
    write_reg(REG_VERT_SHIFT, 24'h800000);
    write_reg(REG_CURVATURE_E, 24'h7FFFFF);
    write_reg(REG_HORIZ_SHIFT, 24'h7FFFFF);
    write_reg(REG_NORMAL_FORCE, 24'h000000);
    send_slip(24'h000000, 18'h3FFFF);
    write_reg(7, 24'h5A5A5A);   // out-of-map index is dropped
    write_reg(REG_NORMAL_FORCE, 24'hFFFFFF);
    send_slip(24'hABCDEF, 18'h3FFFF);
    drain();
  endtask

  // random streams under a series of random register settings
  task automatic test_random_streams();
    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 7; r++)
        if ($urandom_range(1)) write_reg(r, rand_word());
      idle_pct = (phase == 3) ? 0 : 34;   // one phase without gaps
      repeat (45) begin
        // mostly realistic slips, with some anywhere in range
        if ($urandom_range(3) == 0)
          send_slip(rand_word(), MU_W'($urandom()));
        else
          send_slip(SLIP_W'($urandom_range(2 * 65536) - 65536),
                    MU_W'($urandom_range(262143)));
      end
      drain();
    end
    idle_pct = 34;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (120) send_slip(rand_word(), MU_W'($urandom()));
    release_in();
    wait (!hold_off);
    drain();
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        $display("%t unexpected result: actual %0d/%0b", $realtime,
                 out_force_res, out_saturated);
        errors++;
      end else begin
        force_t want;
        want = force_q.pop_front();
        if (want.force_val !== out_force_res) begin
          $display("%t force mismatch: expected %0d actual %0d", $realtime,
                   want.force_val, out_force_res);
          errors++;
        end
        if (want.sat !== out_saturated) begin
          $display("%t saturation mismatch: expected %0b actual %0b",
                   $realtime, want.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  // ready pattern; the long hold-off is counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    coeff[REG_STIFFNESS_B]  = RST_STIFFNESS_B;
    coeff[REG_SHAPE_C]      = RST_SHAPE_C;
    coeff[REG_PEAK_D]       = RST_PEAK_D;
    coeff[REG_CURVATURE_E]  = RST_CURVATURE_E;
    coeff[REG_VERT_SHIFT]   = RST_VERT_SHIFT;
    coeff[REG_HORIZ_SHIFT]  = RST_HORIZ_SHIFT;
    coeff[REG_NORMAL_FORCE] = RST_NORMAL_FORCE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_extremes();
    test_backpressure();
    test_random_streams();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
